/* rtl/core/button_debounce_autorepeat_top_defines.svh */
// Assertion macros for the button debounce block.
`ifndef BUTTON_DEBOUNCE_AUTOREPEAT_TOP_DEFINES_SVH
`define BUTTON_DEBOUNCE_AUTOREPEAT_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define BDA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define BDA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/bda_pkg.sv */
`default_nettype none
package bda_pkg;

  localparam int TIME_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH    = 2;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int PERIOD_W    = 32;
  localparam int BOUNCE_W    = 16;
  localparam int KIND_W      = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AUTO_REPEAT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_PERIOD = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOUNCE_DELAY  = 2'd3;

  localparam logic                OPCODE_EVENT = 1'b1;
  localparam logic [BOUNCE_W-1:0] BOUNCE_RESET = 16'd50;

  typedef enum logic [KIND_W-1:0] {
    KIND_POLL,
    KIND_EVENT,
    KIND_OFF
  } kind_t;

  typedef struct packed {
    logic                auto_repeat;
    logic [PERIOD_W-1:0] repeat_period;
    logic [BOUNCE_W-1:0] bounce_delay;
  } cfg_t;

endpackage
`default_nettype wire

/* rtl/core/button_debounce_autorepeat_top.sv */
// An accepted input word passes the front register, the queue and the back result register to its result word.
// Throughput: one word per cycle while the output is not stalled; the back end updates its press state per taken word.
// A two-entry queue between front and back absorbs output stalls without dropping rate.
// Reset (rst_n low, synchronous): queue and output empty, button released, times zero,
// enable/auto_repeat/repeat_period zero, bounce_delay 50.
`default_nettype none
module button_debounce_autorepeat_top #(
  parameter int TIME_WIDTH = bda_pkg::TIME_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [bda_pkg::IN_TDATA_W-1:0]  in_tdata,   // pin_level, now
  input  wire logic                            in_tuser,   // opcode
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [bda_pkg::OUT_TDATA_W-1:0]      out_tdata,  // fire, first_press, ignored
  input  wire logic                            cfg_we,
  input  wire logic [bda_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  wire logic [bda_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int ENT_W = TIME_WIDTH + 1 + bda_pkg::KIND_W;

  bda_pkg::cfg_t    cfg;
  logic             f_valid, f_ready;
  logic [ENT_W-1:0] f_data;
  logic             b_valid, b_ready;
  logic [ENT_W-1:0] b_data;

  bda_front #(.TIME_WIDTH(TIME_WIDTH), .ENT_W(ENT_W)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .cfg_o      (cfg),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data)
  );

  bda_queue #(.ENT_W(ENT_W), .DEPTH(bda_pkg::QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_data),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_data  (b_data)
  );

  bda_back #(.TIME_WIDTH(TIME_WIDTH), .ENT_W(ENT_W)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_i      (cfg),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

/* rtl/core/bda_front.sv */
`default_nettype none
module bda_front #(
  parameter int TIME_WIDTH = bda_pkg::TIME_WIDTH_DEF,
  parameter int ENT_W      = TIME_WIDTH + 1 + bda_pkg::KIND_W
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [bda_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  wire logic                            in_tuser,
  input  wire logic                            cfg_we,
  input  wire logic [bda_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  wire logic [bda_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output bda_pkg::cfg_t                        cfg_o,
  output logic                                 push_valid,
  input  wire logic                            push_ready,
  output logic [ENT_W-1:0]                     push_data
);

  logic                              vld_r, vld_nxt;
  logic [ENT_W-1:0]                  ent_r;
  logic                              enable_r;
  bda_pkg::cfg_t                     cfg_r;
  bda_pkg::kind_t                    kind;
  logic [TIME_WIDTH-1:0]             now_t;
  logic                              take;

  // classify: polls while disabled are marked for a plain drop
  always_comb begin
    if (in_tuser == bda_pkg::OPCODE_EVENT) begin
      kind = bda_pkg::KIND_EVENT;
    end else if (enable_r) begin
      kind = bda_pkg::KIND_POLL;
    end else begin
      kind = bda_pkg::KIND_OFF;
    end
  end

  assign now_t      = TIME_WIDTH'(in_tdata[32:1]);
  assign in_tready  = !vld_r || push_ready;
  assign take       = in_tvalid && in_tready;
  assign push_valid = vld_r;
  assign push_data  = ent_r;
  assign cfg_o      = cfg_r;

  always_comb begin
    vld_nxt = vld_r;
    if (take) begin
      vld_nxt = 1'b1;
    end else if (push_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r              <= 1'b0;
      enable_r           <= 1'b0;
      cfg_r.auto_repeat  <= 1'b0;
      cfg_r.repeat_period <= '0;
      cfg_r.bounce_delay <= bda_pkg::BOUNCE_RESET;
    end else begin
      vld_r <= vld_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          bda_pkg::REG_ENABLE:        enable_r            <= cfg_wdata[0];
          bda_pkg::REG_AUTO_REPEAT:   cfg_r.auto_repeat   <= cfg_wdata[0];
          bda_pkg::REG_REPEAT_PERIOD: cfg_r.repeat_period <= cfg_wdata;
          bda_pkg::REG_BOUNCE_DELAY:
            cfg_r.bounce_delay <= cfg_wdata[bda_pkg::BOUNCE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ent_r <= {now_t, in_tdata[0], kind};
    end
  end

endmodule
`default_nettype wire

/* rtl/core/bda_queue.sv */
`default_nettype none
module bda_queue #(
  parameter int ENT_W = 34,
  parameter int DEPTH = bda_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_valid,
  output logic                  wr_ready,
  input  wire logic [ENT_W-1:0] wr_data,
  output logic                  rd_valid,
  input  wire logic             rd_ready,
  output logic [ENT_W-1:0]      rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [ENT_W-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign wr_ready = (cnt_r != CNT_W'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/bda_back.sv */
`default_nettype none
module bda_back #(
  parameter int TIME_WIDTH = bda_pkg::TIME_WIDTH_DEF,
  parameter int ENT_W      = TIME_WIDTH + 1 + bda_pkg::KIND_W
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire bda_pkg::cfg_t                   cfg_i,
  input  wire logic                            pop_valid,
  output logic                                 pop_ready,
  input  wire logic [ENT_W-1:0]                pop_data,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [bda_pkg::OUT_TDATA_W-1:0]      out_tdata
);

  localparam int CMP_W = (TIME_WIDTH > bda_pkg::PERIOD_W) ? TIME_WIDTH : bda_pkg::PERIOD_W;

  logic                  was_rel_r, was_rel_nxt;
  logic                  pend_r, pend_nxt;
  logic [TIME_WIDTH-1:0] last_fire_r, last_fire_nxt;
  logic [TIME_WIDTH-1:0] last_acc_r, last_acc_nxt;
  logic                  ovld_r, ovld_nxt;
  logic [2:0]            res_r, res_nxt;

  bda_pkg::kind_t        kind;
  logic                  rel;
  logic [TIME_WIDTH-1:0] now_t;
  logic [TIME_WIDTH-1:0] el_acc, el_fire;
  logic                  bounce_ok, period_ok, step;
  logic                  fire, first, ign;

  assign kind  = bda_pkg::kind_t'(pop_data[bda_pkg::KIND_W-1:0]);
  assign rel   = pop_data[bda_pkg::KIND_W];
  assign now_t = pop_data[ENT_W-1 -: TIME_WIDTH];

  assign el_acc    = now_t - last_acc_r;
  assign el_fire   = now_t - last_fire_r;
  assign bounce_ok = CMP_W'(el_acc) >= CMP_W'(cfg_i.bounce_delay);
  assign period_ok = CMP_W'(el_fire) >= CMP_W'(cfg_i.repeat_period);

  assign pop_ready  = !ovld_r || out_tready;
  assign step       = pop_valid && pop_ready;
  assign out_tvalid = ovld_r;
  assign out_tdata  = {{(bda_pkg::OUT_TDATA_W-3){1'b0}}, res_r};

  always_comb begin
    was_rel_nxt   = was_rel_r;
    pend_nxt      = pend_r;
    last_fire_nxt = last_fire_r;
    last_acc_nxt  = last_acc_r;
    fire          = 1'b0;
    first         = 1'b0;
    ign           = 1'b0;
    unique case (kind)
      bda_pkg::KIND_POLL: begin
        if (!bounce_ok) begin
          ign = 1'b1;
        end else begin
          last_acc_nxt = now_t;
          if ((!rel || pend_r) && period_ok && (cfg_i.auto_repeat || was_rel_r)) begin
            fire          = 1'b1;
            first         = was_rel_r;
            last_fire_nxt = now_t;
            was_rel_nxt   = 1'b0;
          end
          if (rel) begin
            was_rel_nxt = 1'b1;
          end
          pend_nxt = 1'b0;
        end
      end
      bda_pkg::KIND_EVENT: begin
        if (!bounce_ok) begin
          ign = 1'b1;
        end else begin
          last_acc_nxt = now_t;
          if (!rel && was_rel_r && period_ok) begin
            pend_nxt = 1'b1;
          end
          if (rel) begin
            was_rel_nxt = 1'b1;
          end
        end
      end
      default: begin
        ign = 1'b1;
      end
    endcase
    res_nxt = {ign, first, fire};
  end

  always_comb begin
    ovld_nxt = ovld_r;
    if (step) begin
      ovld_nxt = 1'b1;
    end else if (out_tready) begin
      ovld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      was_rel_r   <= 1'b1;
      pend_r      <= 1'b0;
      last_fire_r <= '0;
      last_acc_r  <= '0;
      ovld_r      <= 1'b0;
    end else begin
      ovld_r <= ovld_nxt;
      if (step) begin
        was_rel_r   <= was_rel_nxt;
        pend_r      <= pend_nxt;
        last_fire_r <= last_fire_nxt;
        last_acc_r  <= last_acc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/bda_checker.sv */
`default_nettype none
`include "button_debounce_autorepeat_top_defines.svh"
module bda_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_tvalid,
  input wire logic                           in_tready,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [bda_pkg::OUT_TDATA_W-1:0] out_tdata
);

  logic [3:0] flight_r, flight_nxt;
  logic       in_acc, out_acc;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  always_comb begin
    flight_nxt = flight_r;
    if (in_acc && !out_acc) begin
      flight_nxt = flight_r + 1'b1;
    end else if (out_acc && !in_acc) begin
      flight_nxt = flight_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flight_r <= '0;
    end else begin
      flight_r <= flight_nxt;
    end
  end

  // one result per word: never a result without a word in flight
  `BDA_ASSERT_NOW(a_no_orphan, out_tvalid, flight_r != 4'd0, "result without pending word")
  // a firing is never also a drop
  `BDA_ASSERT_NOW(a_fire_not_ign, out_tvalid && out_tdata[0], !out_tdata[2], "fire and ignored")
  // first_press only with fire
  `BDA_ASSERT_NOW(a_first_fire, out_tvalid && out_tdata[1], out_tdata[0], "first_press without fire")
  `BDA_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata),
                   "stalled result changed")

endmodule

bind button_debounce_autorepeat_top bda_checker u_chk (.*);
`default_nettype wire
